@@ rtl/srlfe_pkg.sv @@
// Shared types, constants and divider step functions for the serial RGB LED frame encoder.
`default_nettype none

package srlfe_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 1024;

  localparam int unsigned PIDX_W   = 16;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned WORD_W   = 24;
  localparam int unsigned CMP_W    = 17;
  localparam int unsigned REM_W    = 11;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 11;

  // Command codes of an input request.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_SLOT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_EN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_SLOTS = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0]  RST_PIXEL_COUNT = 11'd64;
  localparam logic [7:0]        RST_BRIGHTNESS  = 8'd255;
  localparam logic              RST_GAMMA_EN    = 1'b0;
  localparam logic [7:0]        RST_DUTY_ONE    = 8'd57;
  localparam logic [7:0]        RST_DUTY_ZERO   = 8'd28;
  localparam logic [7:0]        RST_LATCH_SLOTS = 8'd48;

  localparam logic [7:0] GAMMA_G = 8'hB0;
  localparam logic [7:0] GAMMA_B = 8'hF0;

  // The brightness divisor is 256 / (brightness + 1); 256 padded to an even width.
  localparam logic [9:0] BDV_DIVIDEND = 10'h100;

  // Two quotient bits are resolved per step.
  localparam int unsigned MOD_STEPS = PIDX_W / 2;
  localparam int unsigned BDV_STEPS = 10 / 2;
  localparam int unsigned CH_STEPS  = CHAN_W / 2;

  localparam logic [4:0] BIT_LAST = 5'd23;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [PIDX_W-1:0] pixel_index;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } in_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       slot_valid;
    logic       frame_end;
    logic       start_refused;
    logic       busy_res;
  } out_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic mod_step;
    logic bdv_step;
    logic ch_step;
    logic store_wr;
    logic slot_rd;
    logic res_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } ctl_sts_t;

  // One restoring division step: returns the quotient bit over the new remainder.
  function automatic logic [REM_W:0] div_bit(input logic [REM_W-1:0] rem,
                                             input logic             din,
                                             input logic [REM_W-1:0] dvs);
    logic [REM_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, dvs}) begin
      div_bit = {1'b1, REM_W'(t - {1'b0, dvs})};
    end else begin
      div_bit = {1'b0, t[REM_W-1:0]};
    end
  endfunction

  // Two chained steps: two quotient bits, most significant first, over the remainder.
  function automatic logic [REM_W+1:0] div_two(input logic [REM_W-1:0] rem,
                                               input logic [1:0]       din,
                                               input logic [REM_W-1:0] dvs);
    logic [REM_W:0] s1;
    logic [REM_W:0] s2;
    s1 = div_bit(rem, din[1], dvs);
    s2 = div_bit(s1[REM_W-1:0], din[0], dvs);
    div_two = {s1[REM_W], s2[REM_W], s2[REM_W-1:0]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/srlfe_ctrl.sv @@
// Controller state machine that sequences clearing, pixel writes, slot reads and results.
`default_nettype none

module srlfe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_cmd,
  output logic                    in_stall,
  output srlfe_pkg::ctl_cmd_t     cmd,
  input  wire srlfe_pkg::ctl_sts_t sts
);
  import srlfe_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_CHDIV  = 3'd3;
  localparam logic [2:0] S_STORE  = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = !sts.clr_done;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          step_nxt = '0;
          unique case (in_cmd)
            CMD_WRITE: state_nxt = S_MOD;
            CMD_SLOT:  state_nxt = S_READ;
            default:   state_nxt = S_RESULT;
          endcase
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cmd.bdv_step = (step_r < 3'(BDV_STEPS));
        if (step_r == 3'(MOD_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_CHDIV;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_CHDIV: begin
        cmd.ch_step = 1'b1;
        if (step_r == 3'(CH_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_STORE;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_STORE: begin
        cmd.store_wr = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_READ: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/srlfe_dpath.sv @@
// Datapath: configuration registers, dividers, pixel store, frame cursors and result register.
`default_nettype none

module srlfe_dpath #(
  parameter int unsigned MAX_PIXELS = srlfe_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire srlfe_pkg::ctl_cmd_t              cmd,
  output srlfe_pkg::ctl_sts_t                   sts,
  input  wire srlfe_pkg::in_t                   in_data,
  input  wire logic                             cfg_we,
  input  wire logic [srlfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srlfe_pkg::CFG_DAT_W-1:0]  cfg_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output srlfe_pkg::out_t                       out_data
);
  import srlfe_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PIXELS);

  // Configuration registers.
  logic [CNT_W-1:0] pixel_count_r;
  logic [7:0]       brightness_r;
  logic             gamma_en_r;
  logic [7:0]       duty_one_r;
  logic [7:0]       duty_zero_r;
  logic [7:0]       latch_slots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= RST_PIXEL_COUNT;
      brightness_r  <= RST_BRIGHTNESS;
      gamma_en_r    <= RST_GAMMA_EN;
      duty_one_r    <= RST_DUTY_ONE;
      duty_zero_r   <= RST_DUTY_ZERO;
      latch_slots_r <= RST_LATCH_SLOTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_COUNT: pixel_count_r <= cfg_data;
        REG_BRIGHTNESS:  brightness_r  <= cfg_data[7:0];
        REG_GAMMA_EN:    gamma_en_r    <= cfg_data[0];
        REG_DUTY_ONE:    duty_one_r    <= cfg_data[7:0];
        REG_DUTY_ZERO:   duty_zero_r   <= cfg_data[7:0];
        REG_LATCH_SLOTS: latch_slots_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective pixel count: zero acts as one, anything above the store depth is clamped.
  logic [CNT_W-1:0] count;
  always_comb begin
    if (pixel_count_r == '0) begin
      count = CNT_W'(1);
    end else if (CMP_W'(pixel_count_r) > CMP_W'(MAX_PIXELS)) begin
      count = CNT_W'(MAX_PIXELS);
    end else begin
      count = pixel_count_r;
    end
  end

  // Captured request and divider registers.
  logic [1:0]        cmd_r;
  logic [PIDX_W-1:0] pidx_sh_r;
  logic [REM_W-1:0]  mod_rem_r;
  logic [9:0]        bdv_sh_r;
  logic [REM_W-1:0]  bdv_rem_r;
  logic [7:0]        red_sh_r, grn_sh_r, blu_sh_r;
  logic [REM_W-1:0]  red_rem_r, grn_rem_r, blu_rem_r;

  logic [REM_W+1:0] mod_t, bdv_t, red_t, grn_t, blu_t;
  logic [REM_W-1:0] bdv_dvs, ch_dvs;

  always_comb begin
    bdv_dvs = REM_W'(9'(brightness_r) + 9'd1);
    ch_dvs  = REM_W'(bdv_sh_r[8:0]);
    mod_t   = div_two(mod_rem_r, pidx_sh_r[PIDX_W-1 -: 2], count);
    bdv_t   = div_two(bdv_rem_r, bdv_sh_r[9:8], bdv_dvs);
    red_t   = div_two(red_rem_r, red_sh_r[7:6], ch_dvs);
    grn_t   = div_two(grn_rem_r, grn_sh_r[7:6], ch_dvs);
    blu_t   = div_two(blu_rem_r, blu_sh_r[7:6], ch_dvs);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_data.cmd;
      pidx_sh_r <= in_data.pixel_index;
      mod_rem_r <= '0;
      bdv_sh_r  <= BDV_DIVIDEND;
      bdv_rem_r <= '0;
      red_sh_r  <= in_data.red;
      grn_sh_r  <= in_data.green;
      blu_sh_r  <= in_data.blue;
      red_rem_r <= '0;
      grn_rem_r <= '0;
      blu_rem_r <= '0;
    end else begin
      if (cmd.mod_step) begin
        pidx_sh_r <= {pidx_sh_r[PIDX_W-3:0], 2'b00};
        mod_rem_r <= mod_t[REM_W-1:0];
      end
      if (cmd.bdv_step) begin
        bdv_sh_r  <= {bdv_sh_r[7:0], bdv_t[REM_W+1:REM_W]};
        bdv_rem_r <= bdv_t[REM_W-1:0];
      end
      // Each channel shift register fills with quotient bits as dividend bits leave.
      if (cmd.ch_step) begin
        red_sh_r  <= {red_sh_r[5:0], red_t[REM_W+1:REM_W]};
        grn_sh_r  <= {grn_sh_r[5:0], grn_t[REM_W+1:REM_W]};
        blu_sh_r  <= {blu_sh_r[5:0], blu_t[REM_W+1:REM_W]};
        red_rem_r <= red_t[REM_W-1:0];
        grn_rem_r <= grn_t[REM_W-1:0];
        blu_rem_r <= blu_t[REM_W-1:0];
      end
    end
  end

  // Gamma scaling and the stored GRB word.
  logic [15:0]       grn_prod, blu_prod;
  logic [7:0]        grn_st, blu_st;
  logic [WORD_W-1:0] store_word;
  logic [AW-1:0]     wr_addr;

  always_comb begin
    grn_prod   = 16'(grn_sh_r) * 16'(GAMMA_G);
    blu_prod   = 16'(blu_sh_r) * 16'(GAMMA_B);
    grn_st     = gamma_en_r ? grn_prod[15:8] : grn_sh_r;
    blu_st     = gamma_en_r ? blu_prod[15:8] : blu_sh_r;
    store_word = {grn_st, red_sh_r, blu_st};
    wr_addr    = AW'(mod_rem_r);
  end

  // Clearing pass after reset.
  logic [AW-1:0] clr_addr_r;
  logic          clr_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_step) begin
      if (clr_addr_r == AW'(MAX_PIXELS - 1)) begin
        clr_done_r <= 1'b1;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // Frame cursors.
  logic [AW-1:0] pix_cur_r, pix_cur_nxt;
  logic [4:0]    bit_cur_r, bit_cur_nxt;
  logic [7:0]    lat_cur_r, lat_cur_nxt;
  logic          busy_r, busy_nxt;
  logic          in_latch_r, in_latch_nxt;

  // Pixel store.
  logic [WORD_W-1:0] store_mem [MAX_PIXELS];
  logic [WORD_W-1:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      store_mem[clr_addr_r] <= '0;
    end else if (cmd.store_wr) begin
      store_mem[wr_addr] <= store_word;
    end
    if (cmd.slot_rd) begin
      rd_word_r <= store_mem[pix_cur_r];
    end
  end

  // Result and frame advance for the request held in cmd_r.
  logic [7:0]       duty;
  logic             slot_valid, frame_end, refused;
  logic [4:0]       bit_sel;
  logic [CMP_W-1:0] cnt_m1;
  logic [8:0]       lat_inc;

  always_comb begin
    pix_cur_nxt  = pix_cur_r;
    bit_cur_nxt  = bit_cur_r;
    lat_cur_nxt  = lat_cur_r;
    busy_nxt     = busy_r;
    in_latch_nxt = in_latch_r;
    duty         = '0;
    slot_valid   = 1'b0;
    frame_end    = 1'b0;
    refused      = 1'b0;
    bit_sel      = BIT_LAST - bit_cur_r;
    cnt_m1       = CMP_W'(count) - CMP_W'(1);
    lat_inc      = 9'(lat_cur_r) + 9'd1;
    unique case (cmd_r)
      CMD_START: begin
        if (busy_r) begin
          refused = 1'b1;
        end else begin
          busy_nxt     = 1'b1;
          in_latch_nxt = 1'b0;
          pix_cur_nxt  = '0;
          bit_cur_nxt  = '0;
          lat_cur_nxt  = '0;
        end
      end
      CMD_SLOT: begin
        if (busy_r) begin
          slot_valid = 1'b1;
          if (!in_latch_r) begin
            duty = rd_word_r[bit_sel] ? duty_one_r : duty_zero_r;
            if (bit_cur_r == BIT_LAST) begin
              bit_cur_nxt = '0;
              if (CMP_W'(pix_cur_r) >= cnt_m1) begin
                pix_cur_nxt = '0;
                if (latch_slots_r == '0) begin
                  frame_end = 1'b1;
                  busy_nxt  = 1'b0;
                end else begin
                  in_latch_nxt = 1'b1;
                  lat_cur_nxt  = '0;
                end
              end else begin
                pix_cur_nxt = pix_cur_r + AW'(1);
              end
            end else begin
              bit_cur_nxt = bit_cur_r + 5'd1;
            end
          end else begin
            // Latch phase ends once the count has reached or passed latch_slots.
            if (lat_inc >= 9'(latch_slots_r)) begin
              frame_end    = 1'b1;
              busy_nxt     = 1'b0;
              in_latch_nxt = 1'b0;
              lat_cur_nxt  = '0;
            end else begin
              lat_cur_nxt = lat_inc[7:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cur_r  <= '0;
      bit_cur_r  <= '0;
      lat_cur_r  <= '0;
      busy_r     <= 1'b0;
      in_latch_r <= 1'b0;
    end else if (cmd.res_load) begin
      pix_cur_r  <= pix_cur_nxt;
      bit_cur_r  <= bit_cur_nxt;
      lat_cur_r  <= lat_cur_nxt;
      busy_r     <= busy_nxt;
      in_latch_r <= in_latch_nxt;
    end
  end

  // Output register.
  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r.duty          <= duty;
      out_data_r.slot_valid    <= slot_valid;
      out_data_r.frame_end     <= frame_end;
      out_data_r.start_refused <= refused;
      out_data_r.busy_res      <= busy_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.clr_done = clr_done_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

@@ rtl/serial_rgb_led_frame_encoder_top.sv @@
// Top level of the serial RGB LED frame encoder: controller, datapath and ports.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall  | in_data (cmd, pixel_index, red, green, blue)
//   out     | output    | out_valid/out_stall| out_data (duty, flags, busy_res)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A pixel write runs from acceptance through 8 steps of the two-bit index modulo divider
// (the brightness divisor runs alongside), 4 steps of the channel dividers, a store write
// and a result state. A slot request runs through a pixel store read and a result state,
// and a start request through a result state alone. After reset the pixel store is cleared
// entry by entry over all MAX_PIXELS entries while requests stay stalled; configuration
// writes are always taken.
// A result waiting under out_stall holds the controller in its result cycle only.
`default_nettype none

module serial_rgb_led_frame_encoder_top #(
  parameter int unsigned MAX_PIXELS = srlfe_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire srlfe_pkg::in_t                   in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output srlfe_pkg::out_t                       out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [srlfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srlfe_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import srlfe_pkg::*;

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  assign cfg_ready = 1'b1;

  srlfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .cmd      (ctl_cmd),
    .sts      (ctl_sts)
  );

  srlfe_dpath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctl_cmd),
    .sts       (ctl_sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/srlfe_checker.sv @@
// Port-level checker for the frame encoder results, bound to the top level.
`default_nettype none

module srlfe_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire srlfe_pkg::out_t out_data
);

  // A stalled result request stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A frame can only end on a slot that was actually driven.
  a_end_is_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.slot_valid && !out_data.busy_res)
    else $error("frame end without a driven slot or with busy still set");

  // A refused start means a frame was still running.
  a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.start_refused |-> out_data.busy_res && !out_data.slot_valid)
    else $error("start refused while not busy");

  // Without a driven slot the duty value is zero.
  a_idle_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.slot_valid |-> out_data.duty == 8'd0)
    else $error("nonzero duty without a driven slot");

endmodule

bind serial_rgb_led_frame_encoder_top srlfe_checker u_srlfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
